/* hw/rtl/lbt_pkg.sv */
`timescale 1ns / 1ps

package lbt_pkg;

    localparam int MAX_NESTING_DEF      = 64;
    localparam int LOOP_NUMBER_BITS_DEF = 16;
    localparam int LOOP_NUMBER_W        = 16;

    // comment modes
    localparam logic [1:0] CM_NONE       = 2'd0;
    localparam logic [1:0] CM_HASH_BLOCK = 2'd1;
    localparam logic [1:0] CM_HASH_LINE  = 2'd2;

    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_LEFT    = 8'h3C;
    localparam logic [7:0] CH_RIGHT   = 8'h3E;
    localparam logic [7:0] CH_OPEN    = 8'h5B;
    localparam logic [7:0] CH_CLOSE   = 8'h5D;
    localparam logic [7:0] CH_INPUT   = 8'h2C;
    localparam logic [7:0] CH_OUTPUT  = 8'h2E;

    typedef enum logic [2:0] {
        OP_PLUS   = 3'd0,
        OP_MINUS  = 3'd1,
        OP_LEFT   = 3'd2,
        OP_RIGHT  = 3'd3,
        OP_OPEN   = 3'd4,
        OP_CLOSE  = 3'd5,
        OP_INPUT  = 3'd6,
        OP_OUTPUT = 3'd7
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_UNMATCHED = 2'd1,
        ST_TOO_DEEP  = 2'd2,
        ST_EXHAUSTED = 2'd3
    } t_status;

    // filtered command handed from the comment filter to the loop control
    typedef struct packed {
        logic    hit;
        t_opcode op;
    } t_cmd;

    // registered result word, loop number travels on its own port
    typedef struct packed {
        logic    valid;
        t_opcode op;
        t_status status;
        logic    from_ram;
    } t_res;

endpackage

/* hw/rtl/lbt_ram.sv */
`timescale 1ns / 1ps

module lbt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/lbt_filter.sv */
`timescale 1ns / 1ps

module lbt_filter (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_en,
    input  logic         i_halted,
    input  logic [1:0]   i_comment_mode,
    input  logic [7:0]   i_source_byte,
    input  logic [7:0]   i_next_byte,
    output lbt_pkg::t_cmd o_cmd
);

    logic    r_line;
    logic    r_block;
    logic    n_line;
    logic    n_block;
    logic    is_cmd;
    lbt_pkg::t_opcode op;

    always_comb begin
        n_line  = r_line;
        n_block = r_block;
        if (i_comment_mode == lbt_pkg::CM_NONE) begin
            n_line  = 1'b0;
            n_block = 1'b0;
        end else begin
            if (i_comment_mode == lbt_pkg::CM_HASH_BLOCK && i_source_byte == lbt_pkg::CH_HASH) begin
                if (i_next_byte == lbt_pkg::CH_HASH) begin
                    n_block = !r_block;
                end else begin
                    n_line = 1'b1;
                end
            end
            if (i_source_byte == lbt_pkg::CH_NEWLINE) begin
                n_line = 1'b0;
            end
            if (i_comment_mode == lbt_pkg::CM_HASH_LINE && i_source_byte == lbt_pkg::CH_HASH) begin
                n_line = 1'b1;
            end
        end
    end

    always_comb begin
        is_cmd = 1'b1;
        op     = lbt_pkg::OP_PLUS;
        case (i_source_byte)
            lbt_pkg::CH_PLUS:   op = lbt_pkg::OP_PLUS;
            lbt_pkg::CH_MINUS:  op = lbt_pkg::OP_MINUS;
            lbt_pkg::CH_LEFT:   op = lbt_pkg::OP_LEFT;
            lbt_pkg::CH_RIGHT:  op = lbt_pkg::OP_RIGHT;
            lbt_pkg::CH_OPEN:   op = lbt_pkg::OP_OPEN;
            lbt_pkg::CH_CLOSE:  op = lbt_pkg::OP_CLOSE;
            lbt_pkg::CH_INPUT:  op = lbt_pkg::OP_INPUT;
            lbt_pkg::CH_OUTPUT: op = lbt_pkg::OP_OUTPUT;
            default:            is_cmd = 1'b0;
        endcase
    end

    // drop commented bytes using the flags after this byte's update
    assign o_cmd.hit = is_cmd && !n_line && !n_block && !i_halted;
    assign o_cmd.op  = op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line  <= 1'b0;
            r_block <= 1'b0;
        end else if (i_en && !i_halted) begin
            r_line  <= n_line;
            r_block <= n_block;
        end
    end

endmodule

/* hw/rtl/lbt_loop_ctrl.sv */
`timescale 1ns / 1ps

module lbt_loop_ctrl #(
    parameter int MAX_NESTING      = lbt_pkg::MAX_NESTING_DEF,
    parameter int LOOP_NUMBER_BITS = lbt_pkg::LOOP_NUMBER_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_adv,
    input  logic                              i_proc,
    input  lbt_pkg::t_cmd                     i_cmd,
    output logic                              o_halted,
    output lbt_pkg::t_res                     o_res,
    output logic [lbt_pkg::LOOP_NUMBER_W-1:0] o_loop_number
);

    localparam int DW = $clog2(MAX_NESTING + 1);
    localparam int AW = (MAX_NESTING > 1) ? $clog2(MAX_NESTING) : 1;
    localparam int CW = LOOP_NUMBER_BITS + 1;

    logic [DW-1:0]               r_depth;
    logic [DW-1:0]               n_depth;
    logic [CW-1:0]               r_count;
    logic [CW-1:0]               n_count;
    logic                        r_halted;
    logic                        n_halted;
    lbt_pkg::t_res               r_res;
    lbt_pkg::t_res               n_res;
    logic [LOOP_NUMBER_BITS-1:0] r_num;
    logic [LOOP_NUMBER_BITS-1:0] n_num;
    logic                        push;
    logic                        pop;
    logic [DW-1:0]               depth_dec;
    logic [LOOP_NUMBER_BITS-1:0] ram_rdata;
    logic [LOOP_NUMBER_BITS-1:0] num_sel;

    assign depth_dec = r_depth - DW'(1);

    always_comb begin
        n_depth        = r_depth;
        n_count        = r_count;
        n_halted       = r_halted;
        n_num          = '0;
        push           = 1'b0;
        pop            = 1'b0;
        n_res.valid    = i_cmd.hit;
        n_res.op       = i_cmd.op;
        n_res.status   = lbt_pkg::ST_OK;
        n_res.from_ram = 1'b0;
        if (i_cmd.hit) begin
            case (i_cmd.op)
                lbt_pkg::OP_OPEN: begin
                    if (r_depth == DW'(MAX_NESTING)) begin
                        n_res.status = lbt_pkg::ST_TOO_DEEP;
                        n_halted     = 1'b1;
                    end else if (r_count[LOOP_NUMBER_BITS]) begin
                        n_res.status = lbt_pkg::ST_EXHAUSTED;
                        n_halted     = 1'b1;
                    end else begin
                        push    = 1'b1;
                        n_num   = r_count[LOOP_NUMBER_BITS-1:0];
                        n_count = r_count + CW'(1);
                        n_depth = r_depth + DW'(1);
                    end
                end
                lbt_pkg::OP_CLOSE: begin
                    if (r_depth == '0) begin
                        n_res.status = lbt_pkg::ST_UNMATCHED;
                        n_halted     = 1'b1;
                    end else begin
                        pop            = 1'b1;
                        n_res.from_ram = 1'b1;
                        n_depth        = depth_dec;
                    end
                end
                default: ;
            endcase
        end
    end

    lbt_ram #(
        .WIDTH (LOOP_NUMBER_BITS),
        .DEPTH (MAX_NESTING)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (i_proc && push),
        .i_waddr (r_depth[AW-1:0]),
        .i_wdata (r_count[LOOP_NUMBER_BITS-1:0]),
        .i_re    (i_proc && pop),
        .i_raddr (depth_dec[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth     <= '0;
            r_count     <= '0;
            r_halted    <= 1'b0;
            r_res.valid <= 1'b0;
        end else begin
            if (i_proc) begin
                r_depth  <= n_depth;
                r_count  <= n_count;
                r_halted <= n_halted;
            end
            if (i_adv) begin
                r_res.valid    <= i_proc && n_res.valid;
                r_res.op       <= n_res.op;
                r_res.status   <= n_res.status;
                r_res.from_ram <= n_res.from_ram;
                r_num          <= n_num;
            end
        end
    end

    assign num_sel       = r_res.from_ram ? ram_rdata : r_num;
    assign o_loop_number = lbt_pkg::LOOP_NUMBER_W'(num_sel);
    assign o_res         = r_res;
    assign o_halted      = r_halted;

endmodule

/* hw/rtl/loop_bracket_tokenizer_top.sv */
`timescale 1ns / 1ps

// Bracket-matching tokenizer for the eight-command loop language. One source
// byte and its lookahead enter per word; commented and non-command bytes are
// dropped, every other byte leaves as one opcode word. Open brackets take the
// next loop number and push it on a MAX_NESTING-deep stack held in a RAM;
// close brackets pop it and report it again. Throughput is one byte per cycle
// unless output stalls, via the input register and the result register with
// the registered stack read. An unmatched close, a full stack or exhausting
// 2^LOOP_NUMBER_BITS loop numbers gives one error word; then all input is
// swallowed without results until reset. The user must write comment_mode via
// i_cfg_we/i_cfg_data only with no word in flight; the block does not check.
module loop_bracket_tokenizer_top #(
    parameter int MAX_NESTING      = lbt_pkg::MAX_NESTING_DEF,
    parameter int LOOP_NUMBER_BITS = lbt_pkg::LOOP_NUMBER_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [1:0]                        i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [7:0]                        i_source_byte,
    input  logic [7:0]                        i_next_byte,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [2:0]                        o_opcode,
    output logic [lbt_pkg::LOOP_NUMBER_W-1:0] o_loop_number,
    output logic [1:0]                        o_status
);

    logic          r_comment_mode;
    logic [1:0]    r_mode;
    logic          r_v0;
    logic [7:0]    r_src;
    logic [7:0]    r_nxt;
    logic          adv;
    logic          proc;
    logic          accept;
    logic          halted;
    lbt_pkg::t_cmd cmd;
    lbt_pkg::t_res res;

    // advance the pipe when the result register is empty or being taken
    assign adv    = !res.valid || !i_out_stall;
    assign proc   = r_v0 && adv;
    assign accept = i_in_valid && !o_in_stall;

    assign o_in_stall = r_v0 && !adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= lbt_pkg::CM_NONE;
            r_comment_mode <= 1'b0;
            r_v0           <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mode         <= i_cfg_data;
                r_comment_mode <= (i_cfg_data != lbt_pkg::CM_NONE);
            end
            if (adv || !r_v0) begin
                r_v0 <= accept;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_src <= i_source_byte;
            r_nxt <= i_next_byte;
        end
    end

    lbt_filter u_filter (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (proc),
        .i_halted       (halted),
        .i_comment_mode (r_comment_mode ? r_mode : lbt_pkg::CM_NONE),
        .i_source_byte  (r_src),
        .i_next_byte    (r_nxt),
        .o_cmd          (cmd)
    );

    lbt_loop_ctrl #(
        .MAX_NESTING      (MAX_NESTING),
        .LOOP_NUMBER_BITS (LOOP_NUMBER_BITS)
    ) u_loop (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_adv         (adv),
        .i_proc        (proc),
        .i_cmd         (cmd),
        .o_halted      (halted),
        .o_res         (res),
        .o_loop_number (o_loop_number)
    );

    assign o_out_valid = res.valid;
    assign o_opcode    = res.op;
    assign o_status    = res.status;

endmodule

/* hw/rtl/lbt_checker.sv */
`timescale 1ns / 1ps

module lbt_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_out_valid,
    input logic                              i_out_stall,
    input logic [2:0]                        o_opcode,
    input logic [lbt_pkg::LOOP_NUMBER_W-1:0] o_loop_number,
    input logic [1:0]                        o_status
);

    // hold a stalled result word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_opcode) && $stable(o_loop_number) && $stable(o_status))
        else $error("stalled result word changed");

    // after an error word leaves, the block is halted and emits nothing
    a_halt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && o_status != lbt_pkg::ST_OK |=> !o_out_valid)
        else $error("result after error word");

    a_plain_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_opcode != lbt_pkg::OP_OPEN && o_opcode != lbt_pkg::OP_CLOSE |->
            o_loop_number == '0 && o_status == lbt_pkg::ST_OK)
        else $error("non-bracket word carries loop number or error");

    a_err_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != lbt_pkg::ST_OK |->
            o_loop_number == '0 &&
            ((o_status == lbt_pkg::ST_UNMATCHED && o_opcode == lbt_pkg::OP_CLOSE) ||
             (o_status == lbt_pkg::ST_TOO_DEEP && o_opcode == lbt_pkg::OP_OPEN) ||
             (o_status == lbt_pkg::ST_EXHAUSTED && o_opcode == lbt_pkg::OP_OPEN)))
        else $error("error status on wrong opcode");

endmodule

bind loop_bracket_tokenizer_top lbt_checker u_lbt_checker (.*);
